[src/amf_pkg.sv]
`default_nettype none
package amf_pkg;
  localparam int unsigned PixW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CFG_ROWS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAXW = 2'd2;
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
endpackage
`default_nettype wire

[src/amf_if.sv]
`default_nettype none
interface amf_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] pixel;
  modport source (output valid, func, row, col, pixel, input ready);
  modport sink (input valid, func, row, col, pixel, output ready);
endinterface

interface amf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_pixel;
  logic [2:0] window_used;
  modport source (output valid, filtered_pixel, window_used, input ready);
  modport sink (input valid, filtered_pixel, window_used, output ready);
endinterface
`default_nettype wire

[src/amf_hist.sv]
`default_nettype none
// Histogram rank selector: counts window pixels into a 256-bin memory, then
// sweeps the bins to find the value of a given rank. The clear and sweep passes each go one bin a cycle.
module amf_hist
  import amf_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            clr,      // start clearing pass
  input  wire logic            add_en,
  input  wire logic [PixW-1:0] add_val,
  input  wire logic            scan,     // start rank search
  input  wire logic [7:0]      rank,     // zero-based
  output logic                 busy,
  output logic                 done,
  output logic [PixW-1:0]      result
);
  typedef enum logic [1:0] {H_IDLE, H_CLR, H_SCAN, H_WAIT} hstate_t;

  logic [7:0] bin_cnt [256];
  hstate_t    state_r;
  logic [7:0] addr_r;
  logic [7:0] acc_r;
  logic [7:0] rd_r;
  logic [7:0] rd_idx_r;
  logic       rd_vld_r;
  logic       hit_r;
  // Add-pipeline: read at stage 0, write back at stage 1 with forwarding.
  logic       add_v_r;
  logic [7:0] add_a_r;
  logic [7:0] add_q_r;
  logic [8:0] sum;

  assign busy = (state_r != H_IDLE);
  assign sum = {1'b0, acc_r} + {1'b0, rd_r};

  always_ff @(posedge clk) begin
    if (add_en) add_q_r <= (add_v_r && add_a_r == add_val) ? add_q_r + 8'd1 : bin_cnt[add_val];
    if (state_r == H_CLR) bin_cnt[addr_r] <= '0;
    else if (add_v_r) bin_cnt[add_a_r] <= add_q_r + 8'd1;
    rd_r <= bin_cnt[addr_r];
    rd_idx_r <= addr_r;
    add_a_r <= add_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      addr_r <= '0;
      acc_r <= '0;
      rd_vld_r <= 1'b0;
      done <= 1'b0;
      hit_r <= 1'b0;
      add_v_r <= 1'b0;
      result <= '0;
    end else begin
      add_v_r <= add_en;
      done <= (state_r == H_WAIT);
      rd_vld_r <= (state_r == H_SCAN);
      unique case (state_r)
        H_IDLE: begin
          addr_r <= '0;
          acc_r <= '0;
          hit_r <= 1'b0;
          if (clr) state_r <= H_CLR;
          else if (scan) state_r <= H_SCAN;
        end
        H_CLR: begin
          addr_r <= addr_r + 8'd1;
          if (addr_r == 8'd255) state_r <= H_IDLE;
        end
        H_SCAN: begin
          addr_r <= addr_r + 8'd1;
          if (rd_vld_r && !hit_r) begin
            if (sum > {1'b0, rank}) begin
              hit_r <= 1'b1;
              result <= rd_idx_r;
            end
            acc_r <= sum[7:0];
          end
          if (addr_r == 8'd255) state_r <= H_WAIT;
        end
        H_WAIT: begin
          if (!hit_r && !(rd_vld_r && sum > {1'b0, rank})) result <= 8'd255;
          else if (!hit_r) result <= rd_idx_r;
          state_r <= H_IDLE;
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  // A search must not start while pixels are still being counted.
  assert property (@(posedge clk) disable iff (!rst_n) state_r == H_SCAN |-> !add_en)
    else $error("add during scan");
  assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(state_r) == H_WAIT)
    else $error("done out of sequence");
  assert property (@(posedge clk) disable iff (!rst_n) state_r == H_CLR |-> !add_v_r)
    else $error("add during clear");
endmodule
`default_nettype wire

[src/adaptive_median_filter.sv]
`default_nettype none
// A write stores the pixel; a query at the border returns the stored pixel;
// an interior query, per window (side w), clears the histogram, fetches w*w
// pixels and searches for the median, with up to three windows.
// Throughput: one item at a time; the frame memory read port and histogram sweep set it.
// Reset: synchronous active-low rst_n restores register defaults; the frame
// memory is not cleared and holds undefined data until written.
module adaptive_median_filter
  import amf_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_WINDOW = 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  amf_in_if.sink                   in_req,
  amf_out_if.source                out_res,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned DW = 14;
  localparam int unsigned CAP0 = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
  localparam int unsigned CAP = (CAP0 < 3) ? 3 : CAP0;
  localparam int unsigned WW = 5;

  typedef enum logic [2:0] {S_IDLE, S_BORD, S_BORD2, S_CLR, S_FETCH, S_SCAN, S_NEXT,
                            S_OUT} state_t;

  logic [PixW-1:0] mem [2**(RW+CW)];
  logic [8:0] rows_cfg_r, cols_cfg_r;
  logic [2:0] maxw_cfg_r;
  state_t     state_r;
  logic [DW-1:0] rq_r, cq_r;
  logic [WW-1:0] w_r, maxw_r;
  logic [DW-1:0] rows_r, cols_r;
  logic [DW-1:0] i_r, j_r;
  logic       rd_v_r, rd_v2_r;
  logic [PixW-1:0] rd_q_r;
  logic [PixW-1:0] med_r;
  logic [WW-1:0] rd_cnt_r;
  logic [RW+CW-1:0] rd_addr;
  logic       fetch_last;
  logic       h_clr, h_scan, h_busy, h_done;
  logic [PixW-1:0] h_res;
  logic [7:0] rank;
  logic [WW-1:0] half, nhalf, nw;
  logic [DW-1:0] rows_e, cols_e;
  logic       in_store, border, grow_ok;
  logic       out_v_r;
  logic [PixW-1:0] out_px_r;
  logic [2:0] out_w_r;
  logic [WW-1:0] mw;

  // Effective frame size and window limit.
  assign rows_e = ({5'd0, rows_cfg_r} > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : {5'd0, rows_cfg_r};
  assign cols_e = ({5'd0, cols_cfg_r} > DW'(MAX_COLS)) ? DW'(MAX_COLS) : {5'd0, cols_cfg_r};
  always_comb begin
    mw = {2'd0, maxw_cfg_r};
    if (mw < WW'(3)) mw = WW'(3);
    if (!mw[0]) mw = mw - WW'(1);
    if (mw > WW'(CAP)) mw = WW'(CAP);
  end

  assign in_store = ({6'd0, in_req.row} < DW'(MAX_ROWS)) && ({6'd0, in_req.col} < DW'(MAX_COLS));
  assign border = (rows_e < DW'(3)) || (cols_e < DW'(3)) || in_req.row == 8'd0 ||
                  in_req.col == 8'd0 || ({6'd0, in_req.row} + DW'(1) >= rows_e) ||
                  ({6'd0, in_req.col} + DW'(1) >= cols_e);
  assign half = w_r >> 1;
  assign nw = w_r + WW'(2);
  assign nhalf = nw >> 1;
  assign grow_ok = (nw <= maxw_r) && (rq_r >= DW'(nhalf)) && (cq_r >= DW'(nhalf)) &&
                   (rq_r + DW'(nhalf) <= rows_r - DW'(1)) &&
                   (cq_r + DW'(nhalf) <= cols_r - DW'(1));
  assign rank = ({3'd0, w_r} * {3'd0, w_r} - 8'd1) >> 1;
  assign rd_addr = (state_r == S_IDLE) ? {RW'(in_req.row), CW'(in_req.col)}
                                       : {RW'(i_r), CW'(j_r)};
  assign fetch_last = (i_r == rq_r + DW'(half)) && (j_r == cq_r + DW'(half));
  assign h_clr = (state_r == S_CLR) && !h_busy && !rd_v_r && (rd_cnt_r == '0);
  assign h_scan = (state_r == S_SCAN) && !h_busy && !rd_v_r && !rd_v2_r && !h_done;

  assign in_req.ready = (state_r == S_IDLE) && !out_v_r;
  assign out_res.valid = out_v_r;
  assign out_res.filtered_pixel = out_px_r;
  assign out_res.window_used = out_w_r;

  // Frame memory: one write and one read a cycle, registered read data.
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready && in_req.func == FUNC_WRITE && in_store)
      mem[{RW'(in_req.row), CW'(in_req.col)}] <= in_req.pixel;
    rd_q_r <= mem[rd_addr];
  end

  amf_hist u_hist (
    .clk, .rst_n, .clr(h_clr), .add_en(rd_v_r), .add_val(rd_q_r), .scan(h_scan),
    .rank, .busy(h_busy), .done(h_done), .result(h_res)
  );

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rows_cfg_r <= 9'd256;
      cols_cfg_r <= 9'd256;
      maxw_cfg_r <= 3'd7;
      out_v_r <= 1'b0;
      rd_v_r <= 1'b0;
      rd_v2_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS: rows_cfg_r <= cfg_data;
          CFG_COLS: cols_cfg_r <= cfg_data;
          CFG_MAXW: maxw_cfg_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (out_v_r && out_res.ready) out_v_r <= 1'b0;
      rd_v2_r <= rd_v_r;
      rd_v_r <= (state_r == S_FETCH);
      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid && in_req.ready && in_req.func == FUNC_QUERY) begin
            rq_r <= {6'd0, in_req.row};
            cq_r <= {6'd0, in_req.col};
            i_r <= {6'd0, in_req.row};
            j_r <= {6'd0, in_req.col};
            rows_r <= rows_e;
            cols_r <= cols_e;
            maxw_r <= mw;
            w_r <= WW'(3);
            rd_cnt_r <= '0;
            if (!in_store) begin
              out_px_r <= '0;
              out_w_r <= '0;
              out_v_r <= 1'b1;
            end else if (border) state_r <= S_BORD;
            else state_r <= S_CLR;
          end
        end
        S_BORD: state_r <= S_BORD2;
        S_BORD2: begin
          out_px_r <= rd_q_r;
          out_w_r <= '0;
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        // Start one clearing pass, then wait for it to finish.
        S_CLR: begin
          i_r <= rq_r - DW'(half);
          j_r <= cq_r - DW'(half);
          if (h_clr) rd_cnt_r <= WW'(1);
          else if (rd_cnt_r != '0 && !h_busy) begin
            rd_cnt_r <= '0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (j_r == cq_r + DW'(half)) begin
            j_r <= cq_r - DW'(half);
            i_r <= i_r + DW'(1);
          end else j_r <= j_r + DW'(1);
          if (fetch_last) state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (h_done) begin
            med_r <= h_res;
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if ((med_r == 8'd0 || med_r == 8'd255) && grow_ok) begin
            w_r <= nw;
            rd_cnt_r <= '0;
            state_r <= S_CLR;
          end else state_r <= S_OUT;
        end
        S_OUT: begin
          out_px_r <= med_r;
          out_w_r <= w_r[2:0];
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_res.ready |=> out_v_r) else $error("result lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH |-> !h_busy) else $error("fetch while histogram busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> state_r == S_IDLE) else $error("accept while working");
endmodule
`default_nettype wire
